// ===== sv/bsl_pkg.sv =====
// Shared constants and types for the bounded sequential list.
package bsl_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_MIN    = 3'd3,
    ACT_ODD    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// ===== sv/bsl_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module bsl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bsl_ctrl.sv =====
// Sequencer: decodes a request and walks the entry RAM one word per cycle.
module bsl_ctrl
  import bsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [WORD_W-1:0]   value,
  input  logic [INDEX_W-1:0]  index,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  output mem_req_t            mem,
  input  logic [WORD_W-1:0]   rdata
);

  state_t              state, state_next;
  logic [CNT_W-1:0]    n, n_next;
  logic [CNT_W-1:0]    rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]    wr_j, wr_j_next;
  logic                rvalid, rvalid_next;
  logic                found, found_next;
  logic [ACTION_W-1:0] act, act_next;
  logic [WORD_W-1:0]   val, val_next;
  logic [WORD_W-1:0]   mn, mn_next;
  logic                res_ok, res_ok_next;
  logic [WORD_W-1:0]   res_data, res_data_next;
  logic                idx_ok;
  logic                last;
  logic                hit;
  logic                even;

  assign idx_ok = CMP_W'(index) < CMP_W'(n);
  assign last   = rvalid && (pos == n - CNT_W'(1));
  assign hit    = !found && (rdata == val);
  assign even   = !rdata[0];

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.ok    = res_ok;
  assign res.data  = res_data;
  assign res.count = COUNT_W'(n);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (action) inside
            ACT_READ:                   state_next = idx_ok ? S_READ : S_DONE;
            ACT_REMOVE, ACT_MIN, ACT_ODD: state_next = (n != '0) ? S_SCAN : S_DONE;
            default:                    state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    n_next        = n;
    rd_ptr_next   = rd_ptr;
    pos_next      = pos;
    wr_j_next     = wr_j;
    rvalid_next   = 1'b0;
    found_next    = found;
    act_next      = act;
    val_next      = val;
    mn_next       = mn;
    res_ok_next   = res_ok;
    res_data_next = res_data;
    mem.we        = 1'b0;
    mem.waddr     = '0;
    mem.wdata     = '0;
    mem.raddr     = rd_ptr[ADDR_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          act_next      = action;
          val_next      = value;
          rd_ptr_next   = '0;
          pos_next      = '0;
          wr_j_next     = '0;
          found_next    = 1'b0;
          res_ok_next   = 1'b0;
          res_data_next = '0;
          case (action) inside
            ACT_INSERT: begin
              if (n < CNT_W'(CAPACITY)) begin
                mem.we      = 1'b1;
                mem.waddr   = n[ADDR_W-1:0];
                mem.wdata   = value;
                n_next      = n + CNT_W'(1);
                res_ok_next = 1'b1;
              end
            end
            ACT_READ: mem.raddr = ADDR_W'(index);
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_ptr < n) begin
          rd_ptr_next = rd_ptr + CNT_W'(1);
          rvalid_next = 1'b1;
        end
        if (rvalid) begin
          pos_next = pos + CNT_W'(1);
          case (act)
            ACT_REMOVE: begin
              if (hit) begin
                found_next = 1'b1;
              end else if (found) begin
                // close the gap behind the removed entry
                mem.we    = 1'b1;
                mem.waddr = ADDR_W'(pos - CNT_W'(1));
                mem.wdata = rdata;
              end
              if (last) begin
                res_ok_next = found || hit;
                if (found || hit) begin
                  n_next = n - CNT_W'(1);
                end
              end
            end
            ACT_MIN: begin
              if ((pos == '0) || ($signed(rdata) < $signed(mn))) begin
                mn_next = rdata;
              end
              if (last) begin
                res_ok_next = 1'b1;
                res_data_next = ((pos == '0) || ($signed(rdata) < $signed(mn))) ? rdata : mn;
              end
            end
            default: begin
              // keep even words, packed from the bottom
              if (even) begin
                mem.we    = 1'b1;
                mem.waddr = wr_j[ADDR_W-1:0];
                mem.wdata = rdata;
                wr_j_next = wr_j + CNT_W'(1);
              end
              if (last) begin
                res_ok_next = 1'b1;
                n_next      = even ? wr_j + CNT_W'(1) : wr_j;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_ok_next   = 1'b1;
        res_data_next = rdata;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      n      <= n_next;
      rvalid <= rvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    pos      <= pos_next;
    wr_j     <= wr_j_next;
    found    <= found_next;
    act      <= act_next;
    val      <= val_next;
    mn       <= mn_next;
    res_ok   <= res_ok_next;
    res_data <= res_data_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (pos < n) && (state == S_SCAN))
    else $error("read data beyond the held entries");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && act == ACT_ODD) |-> (wr_j <= pos) && (pos <= rd_ptr))
    else $error("compaction write overtook the read pointer");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && action == ACT_INSERT && n < CNT_W'(CAPACITY))
      |=> n == $past(n) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_ready) |=> (state == S_DONE) && $stable(res))
    else $error("pending result changed");
`endif

endmodule

// ===== sv/bounded_sequential_list.sv =====
// Bounded sequential list: insert, remove, read, minimum and even-only compaction.
// Insert and requests refused at decode go straight to the result; read takes one RAM
// read; remove, minimum and compaction scan the n entries held. One request at a time;
// the scan actions walk the entry RAM at one word per cycle through its single read port.
// Reset (rst, synchronous) empties the list at once; entry contents are left as they are.
module bounded_sequential_list
  import bsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[2:0], value[34:3], index[38:35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // ok[0], data[32:1], count[37:33], zero pad
);

  mem_req_t          mem;
  logic [WORD_W-1:0] rdata;
  res_t              res;
  res_t              out_res;
  logic              res_valid;
  logic              load;

  // result register frees the core as soon as a result is parked
  assign load = !m_tvalid || m_tready;

  bsl_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem.we),
    .waddr(mem.waddr),
    .wdata(mem.wdata),
    .raddr(mem.raddr),
    .rdata(rdata)
  );

  bsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .action   (s_tdata[2:0]),
    .value    (s_tdata[34:3]),
    .index    (s_tdata[38:35]),
    .res_valid(res_valid),
    .res_ready(load),
    .res      (res),
    .mem      (mem),
    .rdata    (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.count, out_res.data, out_res.ok};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded sequential list: directed table, then random requests.
module tb_top;
  import bsl_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_BAD_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_BAD_LAST  = 3'd7;
  localparam int RANDOM_REQS = 900;
  localparam int QUIET_TAIL  = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [WORD_W-1:0]   val;
    logic [INDEX_W-1:0]  idx;
    int                  reps;
    bit                  typed;
    res_t                want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // predictor copy of the list
  logic [WORD_W-1:0] words [CAPACITY];
  int                fill = 0;

  res_t     result_q [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       checked = 0;
  int       cycles = 0;
  int       act_seen [8];
  int       full_hits = 0;
  int       empty_hits = 0;
  bit       idle_on = 1'b0;
  int       stall_left = 0;

  bounded_sequential_list uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycles,
               result_q.size());
      $display("bounded_sequential_list regression: fail");
      $finish;
    end
  end

  // receiver stalls in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic res_t list_apply(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] val,
                                      logic [INDEX_W-1:0] idx);
    res_t r;
    int   pos;
    int   keep;
    r = '0;
    case (act)
      ACT_INSERT: if (fill < CAPACITY) begin
        words[fill] = val;
        fill++;
        r.ok = 1'b1;
      end
      ACT_REMOVE: begin
        pos = 0;
        while (pos < fill && words[pos] != val) pos++;
        if (pos < fill) begin
          for (int k = pos + 1; k < fill; k++) words[k-1] = words[k];
          fill--;
          r.ok = 1'b1;
        end
      end
      ACT_READ: if (idx < fill) begin
        r.data = words[idx];
        r.ok = 1'b1;
      end
      ACT_MIN: if (fill > 0) begin
        r.data = words[0];
        for (int k = 1; k < fill; k++)
          if ($signed(words[k]) < $signed(r.data)) r.data = words[k];
        r.ok = 1'b1;
      end
      ACT_ODD: if (fill > 0) begin
        keep = 0;
        for (int k = 0; k < fill; k++) begin
          if (!words[k][0]) begin
            words[keep] = words[k];
            keep++;
          end
        end
        fill = keep;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  // drives one request, optionally after a gap, and records the expected result on accept
  task automatic send_req(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] val,
                          logic [INDEX_W-1:0] idx, bit typed, res_t want);
    res_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, idx, val, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    act_seen[act]++;
    if (fill == 0) empty_hits++;
    if (act == ACT_INSERT && fill == CAPACITY) full_hits++;
    predicted = list_apply(act, val, idx);
    result_q.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] val,
                         logic [INDEX_W-1:0] idx, int reps, bit typed, logic ok,
                         logic [WORD_W-1:0] data, logic [COUNT_W-1:0] count);
    dir_row_t row;
    row.act = act;
    row.val = val;
    row.idx = idx;
    row.reps = reps;
    row.typed = typed;
    row.want.ok = ok;
    row.want.data = data;
    row.want.count = count;
    dir_rows.push_back(row);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    int                roll;
    logic [WORD_W-1:0] v;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      v = WORD_W'(int'($urandom_range(0, 15)) - 8);
    end else if (roll < 6) begin
      case ($urandom_range(0, 4))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = '1;
        3: v = '0;
        default: v = 32'd1;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(bit grow);
    int roll;
    int ins_w;
    int frac;
    roll = $urandom_range(0, 99);
    ins_w = grow ? 65 : 25;
    if (roll < 2) return ACTION_W'(ACT_BAD_FIRST + $urandom_range(0, 2));
    if (roll < 2 + ins_w) return ACT_INSERT;
    frac = (roll - 2 - ins_w) * 100 / (98 - ins_w);
    if (frac < 45) return ACT_REMOVE;
    if (frac < 70) return ACT_READ;
    if (frac < 90) return ACT_MIN;
    return ACT_ODD;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        checked++;
        if (m_tdata[0] !== want.ok) begin
          $display("%0t ok mismatch: expected %b, actual %b", $time, want.ok, m_tdata[0]);
          errors++;
        end
        if (m_tdata[32:1] !== want.data) begin
          $display("%0t data mismatch: expected %h, actual %h", $time, want.data,
                   m_tdata[32:1]);
          errors++;
        end
        if (m_tdata[37:33] !== want.count) begin
          $display("%0t count mismatch: expected %0d, actual %0d", $time, want.count,
                   m_tdata[37:33]);
          errors++;
        end
      end
    end
  end

  initial begin
    bit                  grow;
    logic [ACTION_W-1:0] act;
    logic [WORD_W-1:0]   val;
    logic [INDEX_W-1:0]  idx;
    res_t                none;
    none = '0;
    foreach (act_seen[k]) act_seen[k] = 0;

    // empty list: every action but insert fails
    add_row(ACT_READ,      32'd0,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd0);
    add_row(ACT_MIN,       32'd0,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd0);
    add_row(ACT_REMOVE,    32'd5,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd0);
    add_row(ACT_ODD,       32'd0,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd0);
    add_row(ACT_BAD_FIRST, 32'hFFFF_FFFF, 4'd15, 1, 1'b1, 1'b0, 32'd0,       5'd0);
    add_row(ACT_BAD_LAST,  32'd0,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd0);
    // fill to capacity with extremes, a negative odd and duplicates
    add_row(ACT_INSERT,    32'h7FFF_FFFF, 4'd0, 1, 1'b1, 1'b1, 32'd0,        5'd1);
    add_row(ACT_INSERT,    32'h8000_0000, 4'd0, 1, 1'b1, 1'b1, 32'd0,        5'd2);
    add_row(ACT_INSERT,    32'hFFFF_FFFF, 4'd0, 1, 1'b1, 1'b1, 32'd0,        5'd3);
    add_row(ACT_INSERT,    32'd0,        4'd0,  1, 1'b1, 1'b1, 32'd0,        5'd4);
    add_row(ACT_INSERT,    32'hFFFF_FFFD, 4'd0, 1, 1'b1, 1'b1, 32'd0,        5'd5);
    add_row(ACT_INSERT,    32'd6,        4'd0, 11, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_INSERT,    32'd1,        4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd16);
    add_row(ACT_READ,      32'd0,        4'd15, 1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_READ,      32'd0,        4'd0,  1, 1'b1, 1'b1, 32'h7FFF_FFFF, 5'd16);
    add_row(ACT_MIN,       32'd0,        4'd0,  1, 1'b1, 1'b1, 32'h8000_0000, 5'd16);
    add_row(ACT_REMOVE,    32'd12345,    4'd0,  1, 1'b1, 1'b0, 32'd0,        5'd16);
    // remove takes the first of the duplicates, then an extreme
    add_row(ACT_REMOVE,    32'd6,        4'd0,  1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_REMOVE,    32'h8000_0000, 4'd0, 1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_READ,      32'd0,        4'd15, 1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_ODD,       32'd0,        4'd0,  1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_MIN,       32'd0,        4'd0,  1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_READ,      32'd0,        4'd0,  1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_REMOVE,    32'hFFFF_FFFF, 4'd0, 1, 1'b0, 1'b0, 32'd0,        5'd0);
    add_row(ACT_BAD_FIRST + 3'd1, 32'd0, 4'd7,  1, 1'b0, 1'b0, 32'd0,        5'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;

    foreach (dir_rows[r])
      repeat (dir_rows[r].reps)
        send_req(dir_rows[r].act, dir_rows[r].val, dir_rows[r].idx, dir_rows[r].typed,
                 dir_rows[r].want);
    drain_results();

    grow = 1'b1;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) grow = (fill < CAPACITY / 2) ? ($urandom_range(0, 3) != 0)
                                                    : ($urandom_range(0, 3) == 0);
      idle_on <= (n < RANDOM_REQS - QUIET_TAIL) && ((n / 100) % 3 != 2);
      if (n == RANDOM_REQS / 2) drain_results();
      act = pick_action(grow);
      idx = INDEX_W'($urandom_range(0, CAPACITY - 1));
      if (act == ACT_REMOVE && fill > 0 && $urandom_range(0, 9) < 7)
        val = words[$urandom_range(0, fill - 1)];
      else
        val = pick_value();
      // reads mostly aim at held positions
      if (act == ACT_READ && fill > 0 && $urandom_range(0, 3) != 0)
        idx = INDEX_W'($urandom_range(0, fill - 1));
      send_req(act, val, idx, 1'b0, none);
    end

    drain_results();
    repeat (CAPACITY + 8) @(posedge clk);

    $display("covered: %0d insert, %0d remove, %0d read, %0d minimum, %0d odd purge",
             act_seen[ACT_INSERT], act_seen[ACT_REMOVE], act_seen[ACT_READ],
             act_seen[ACT_MIN], act_seen[ACT_ODD]);
    $display("%0d undefined, %0d results checked, %0d full inserts, %0d on an empty list",
             act_seen[5] + act_seen[6] + act_seen[7], checked, full_hits, empty_hits);
    if (errors == 0 && result_q.size() == 0)
      $display("bounded_sequential_list regression: pass");
    else
      $display("bounded_sequential_list regression: fail");
    $finish;
  end

endmodule
